// File: sv/ctu_pkg.sv
// Package with shared types and constants of the cascaded timer unit.
package ctu_pkg;
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;
  localparam logic [1:0] OFF_LOW  = 2'd0;
  localparam logic [1:0] OFF_HIGH = 2'd1;
  localparam logic [1:0] OFF_CTRL = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  channel;
    logic [1:0]  register_offset;
    logic [7:0]  write_data;
    logic [15:0] elapsed_cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [3:0]  irq_raised;
    logic [15:0] overflows_timer0;
    logic [15:0] overflows_timer1;
    logic [26:0] cycles_until_irq;
    logic        irq_estimate_valid;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [16:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quotient;
    logic [16:0] remainder;
  } div_rsp_t;

  function automatic logic [3:0] tick_shift(input logic [1:0] s);
    case (s)
      2'd0: tick_shift = 4'd0;
      2'd1: tick_shift = 4'd6;
      2'd2: tick_shift = 4'd8;
      default: tick_shift = 4'd10;
    endcase
  endfunction

  function automatic logic [9:0] tick_mask(input logic [1:0] s);
    case (s)
      2'd0: tick_mask = 10'h000;
      2'd1: tick_mask = 10'h03F;
      2'd2: tick_mask = 10'h0FF;
      default: tick_mask = 10'h3FF;
    endcase
  endfunction
endpackage

// File: sv/ctu_stream_if.sv
// Valid/ready channel interface that carries one payload beat.
interface ctu_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: sv/cascaded_timer_unit.sv
// Top level of the cascaded timer unit: register file, sequencer, result register.
// Sequence: a read, a byte write or an unused opcode goes through the estimate walk; a
// control write first updates the chain flags; a run first advances each channel, and an
// overflowing channel step waits on the shared divider.
// Throughput: one item at a time; the input is not ready until the result beat is taken.
// Reset (synchronous, rst high) clears all timer state and the result valid flag.
module cascaded_timer_unit #(
  parameter int TIMER_COUNT = 4
) (
  input logic clk,
  input logic rst,
  ctu_stream_if.sink   in_ch,
  ctu_stream_if.source out_ch
);
  localparam int CW = $clog2(TIMER_COUNT + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RUNCH  = 4'd1;
  localparam logic [3:0] S_ADV    = 4'd2;
  localparam logic [3:0] S_DIVW   = 4'd3;
  localparam logic [3:0] S_POST   = 4'd4;
  localparam logic [3:0] S_EST    = 4'd5;
  localparam logic [3:0] S_OUT    = 4'd6;
  localparam logic [3:0] S_CHAIN  = 4'd7;

  logic [15:0] count_value [TIMER_COUNT];
  logic [15:0] reload_value [TIMER_COUNT];
  logic signed [10:0] prescale_residue [TIMER_COUNT];
  logic [1:0]  prescale_select [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] cascade_on, irq_on, timer_on, feeds_irq_chain;

  logic [3:0] state;
  ctu_pkg::in_item_t item;
  ctu_pkg::out_item_t res;
  logic out_valid;

  // run walk: rn is the outer channel, an is the channel being advanced.
  logic [CW-1:0] rn, an;
  logic [16:0]   ticks;
  logic [16:0]   ovf;
  logic          linked;

  ctu_pkg::div_req_t dreq;
  ctu_pkg::div_rsp_t drsp;

  ctu_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.payload = res;

  function automatic logic ch_ok_in(input logic [1:0] c);
    ch_ok_in = {1'b0, c} < 3'(TIMER_COUNT);
  endfunction

  // Current channel views.
  logic [1:0] an_i, rn_i;
  assign an_i = an[1:0];
  assign rn_i = rn[1:0];

  logic [16:0] limit, limit_r;
  assign limit   = 17'h10000 - {1'b0, count_value[an_i]};
  assign limit_r = 17'h10000 - {1'b0, reload_value[an_i]};

  logic signed [17:0] avail;
  assign avail = 18'(prescale_residue[rn_i]) + $signed({2'b0, item.elapsed_cycles});

  // Estimate for the channel rn.
  logic [16:0] limit_est;
  assign limit_est = 17'h10000 - {1'b0, count_value[rn_i]};
  logic [26:0] need;
  logic [1:0]  ps;
  assign ps = prescale_select[rn_i];
  assign need = ({10'b0, limit_est} << ctu_pkg::tick_shift(ps)) -
                27'($signed(prescale_residue[rn_i]));

  // Byte returned by a read beat; zero for anything else.
  logic [7:0] read_byte;
  always_comb begin
    read_byte = '0;
    if (in_ch.payload.opcode == ctu_pkg::OP_READ && ch_ok_in(in_ch.payload.channel)) begin
      case (in_ch.payload.register_offset)
        ctu_pkg::OFF_LOW: read_byte = count_value[in_ch.payload.channel][7:0];
        ctu_pkg::OFF_HIGH: read_byte = count_value[in_ch.payload.channel][15:8];
        ctu_pkg::OFF_CTRL: read_byte = {timer_on[in_ch.payload.channel],
            irq_on[in_ch.payload.channel], 3'b0, cascade_on[in_ch.payload.channel],
            prescale_select[in_ch.payload.channel]};
        default: read_byte = '0;
      endcase
    end
  end

  // A control write triggers the chain flag update before the estimate.
  logic ctrl_write;
  assign ctrl_write = in_ch.payload.opcode == ctu_pkg::OP_WRITE &&
                      ch_ok_in(in_ch.payload.channel) &&
                      in_ch.payload.register_offset == ctu_pkg::OFF_CTRL;

  always_ff @(posedge clk) begin
    if (rst) begin
      dreq.start <= 1'b0;
      state <= S_IDLE;
      out_valid <= 1'b0;
      cascade_on <= '0;
      irq_on <= '0;
      timer_on <= '0;
      feeds_irq_chain <= '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        count_value[i] <= '0;
        reload_value[i] <= '0;
        prescale_residue[i] <= '0;
        prescale_select[i] <= '0;
      end
    end else begin
      // The divider starts on the cycle after an overflow is seen.
      dreq.start <= (state == S_ADV) && (ticks >= limit);
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item <= in_ch.payload;
            res <= '{read_data: read_byte, irq_raised: '0, overflows_timer0: '0,
                     overflows_timer1: '0, cycles_until_irq: '0,
                     irq_estimate_valid: 1'b0};
            if (in_ch.payload.opcode == ctu_pkg::OP_WRITE &&
                ch_ok_in(in_ch.payload.channel)) begin
              case (in_ch.payload.register_offset)
                ctu_pkg::OFF_LOW:
                  reload_value[in_ch.payload.channel][7:0] <= in_ch.payload.write_data;
                ctu_pkg::OFF_HIGH:
                  reload_value[in_ch.payload.channel][15:8] <= in_ch.payload.write_data;
                ctu_pkg::OFF_CTRL: begin
                  prescale_select[in_ch.payload.channel] <= in_ch.payload.write_data[1:0];
                  irq_on[in_ch.payload.channel] <= in_ch.payload.write_data[6];
                  timer_on[in_ch.payload.channel] <= in_ch.payload.write_data[7];
                  if (in_ch.payload.channel != 2'd0)
                    cascade_on[in_ch.payload.channel] <= in_ch.payload.write_data[2];
                  if (!timer_on[in_ch.payload.channel] && in_ch.payload.write_data[7]) begin
                    prescale_residue[in_ch.payload.channel] <= -11'sd2;
                    count_value[in_ch.payload.channel] <=
                      reload_value[in_ch.payload.channel];
                  end
                end
                default: ;
              endcase
            end
            if (ctrl_write) begin
              rn <= CW'(TIMER_COUNT - 1);
              linked <= 1'b0;
              state <= S_CHAIN;
            end else if (in_ch.payload.opcode == ctu_pkg::OP_RUN) begin
              rn <= '0;
              state <= S_RUNCH;
            end else begin
              rn <= '0;
              state <= S_EST;
            end
          end
        end
        // Chain flags, one channel per cycle from the top down.
        S_CHAIN: begin
          feeds_irq_chain[rn_i] <= timer_on[rn_i] && linked && !cascade_on[rn_i];
          if (!timer_on[rn_i]) linked <= 1'b0;
          else if (linked) linked <= cascade_on[rn_i];
          else if (cascade_on[rn_i] && irq_on[rn_i]) linked <= 1'b1;
          if (rn == '0) state <= S_EST;
          else rn <= rn - CW'(1);
        end
        S_RUNCH: begin
          if (rn == CW'(TIMER_COUNT)) begin
            rn <= '0;
            state <= S_EST;
          end else if (timer_on[rn_i] && !cascade_on[rn_i]) begin
            if (avail < 0) begin
              prescale_residue[rn_i] <= avail[10:0];
              rn <= rn + CW'(1);
            end else begin
              prescale_residue[rn_i] <=
                $signed({1'b0, avail[9:0] & ctu_pkg::tick_mask(prescale_select[rn_i])});
              ticks <= 17'(avail[16:0] >> ctu_pkg::tick_shift(prescale_select[rn_i]));
              an <= rn;
              state <= S_ADV;
            end
          end else begin
            rn <= rn + CW'(1);
          end
        end
        S_ADV: begin
          if (ticks >= limit) begin
            count_value[an_i] <= reload_value[an_i];
            ticks <= ticks - limit;
            dreq.dividend <= ticks - limit;
            dreq.divisor <= limit_r;
            state <= S_DIVW;
          end else begin
            count_value[an_i] <= 16'(count_value[an_i] + ticks[15:0]);
            rn <= rn + CW'(1);
            state <= S_RUNCH;
          end
        end
        S_DIVW: begin
          if (drsp.done) begin
            ovf <= 17'(drsp.quotient + 17'd1);
            count_value[an_i] <= 16'(count_value[an_i] + drsp.remainder[15:0]);
            state <= S_POST;
          end
        end
        S_POST: begin
          if (irq_on[an_i]) res.irq_raised[an_i] <= 1'b1;
          if (an == CW'(0)) res.overflows_timer0 <= res.overflows_timer0 + ovf[15:0];
          if (an == CW'(1)) res.overflows_timer1 <= res.overflows_timer1 + ovf[15:0];
          if (an + CW'(1) < CW'(TIMER_COUNT) && cascade_on[an_i + 2'd1]) begin
            an <= an + CW'(1);
            ticks <= ovf;
            state <= S_ADV;
          end else begin
            rn <= rn + CW'(1);
            state <= S_RUNCH;
          end
        end
        // Estimate: minimum over channels, one per cycle.
        S_EST: begin
          if (rn == CW'(TIMER_COUNT)) state <= S_OUT;
          else begin
            if ((irq_on[rn_i] || feeds_irq_chain[rn_i]) && timer_on[rn_i] &&
                !cascade_on[rn_i]) begin
              if (!res.irq_estimate_valid || need < res.cycles_until_irq) begin
                res.cycles_until_irq <= need;
                res.irq_estimate_valid <= 1'b1;
              end
            end
            rn <= rn + CW'(1);
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: sv/ctu_divider.sv
// Shared restoring divider, one quotient bit per cycle, 17-bit operands.
module ctu_divider (
  input  logic               clk,
  input  logic               rst,
  input  ctu_pkg::div_req_t  req,
  output ctu_pkg::div_rsp_t  rsp
);
  logic [16:0] quo;
  logic [16:0] rem;
  logic [16:0] dsr;
  logic [4:0]  bitcnt;
  logic        busy;
  logic        done;
  logic [17:0] trial;

  assign trial = {rem, quo[16]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (bitcnt == 5'd16);
      if (req.start) begin
        busy   <= 1'b1;
        quo    <= req.dividend;
        rem    <= '0;
        dsr    <= req.divisor;
        bitcnt <= 5'd0;
      end else if (busy) begin
        if (!trial[17]) begin
          rem <= trial[16:0];
          quo <= {quo[15:0], 1'b1};
        end else begin
          rem <= {rem[15:0], quo[16]};
          quo <= {quo[15:0], 1'b0};
        end
        bitcnt <= bitcnt + 5'd1;
        if (bitcnt == 5'd16) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp = {done, quo, rem};
endmodule

// File: sv/ctu_checker.sv
// Port-level checker for the cascaded timer unit, bound to the top level.
module ctu_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input ctu_pkg::out_item_t res
);
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while a result waits");
  a_est_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.irq_estimate_valid |-> res.cycles_until_irq == 27'd0)
    else $error("estimate without valid");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res))
    else $error("result dropped");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind cascaded_timer_unit ctu_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .res(out_ch.payload)
);

// File: dv/cascaded_timer_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the cascaded timer unit with a built-in timer predictor.
module cascaded_timer_unit_test;
  localparam int CHANNELS = 4;
  // Opcode 3 is outside the package; it must leave all timer state alone.
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam logic [1:0] OFF_UNUSED = 2'd3;
  // Control byte layout.
  localparam int CTRL_CASCADE = 2;
  localparam int CTRL_IRQ = 6;
  localparam int CTRL_ENABLE = 7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  ctu_stream_if #(.payload_t(ctu_pkg::in_item_t)) in_ch (clk);
  ctu_stream_if #(.payload_t(ctu_pkg::out_item_t)) out_ch (clk);

  cascaded_timer_unit #(.TIMER_COUNT(CHANNELS)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the timer state, advanced once per accepted input beat.
  logic [15:0] shadow_count [CHANNELS];
  logic [15:0] shadow_reload [CHANNELS];
  int          shadow_residue [CHANNELS];
  logic [1:0]  shadow_prescale [CHANNELS];
  logic        shadow_cascade [CHANNELS];
  logic        shadow_irq [CHANNELS];
  logic        shadow_enable [CHANNELS];
  logic        shadow_feeds_irq [CHANNELS];

  ctu_pkg::out_item_t pending_results[$];
  int        error_count = 0;
  int        result_count = 0;
  int        overflow_beats = 0;
  int        irq_beats = 0;

  // Idle behavior: the quiet flag turns off random gaps on both sides, and the
  // stall request holds the receiver off for a counted stretch of cycles.
  bit quiet = 1'b0;
  int stall_request = 0;

  // Chain flags mark a free-running timer whose overflows ripple through
  // cascading successors up to one that has its irq enabled.
  function automatic void refresh_chains();
    logic linked;
    linked = 1'b0;
    for (int n = CHANNELS - 1; n >= 0; n--) begin
      shadow_feeds_irq[n] = 1'b0;
      if (!shadow_enable[n]) begin
        linked = 1'b0;
      end else if (linked) begin
        linked = shadow_cascade[n];
        if (!linked) shadow_feeds_irq[n] = 1'b1;
      end else if (shadow_cascade[n] && shadow_irq[n]) begin
        linked = 1'b1;
      end
    end
  endfunction

  // Adds ticks to channel n; each overflow count carries into the next
  // channel when that one cascades.
  function automatic void add_ticks(int n, logic [31:0] ticks, ref logic [3:0] irq,
                                    ref logic [31:0] ovf0, ref logic [31:0] ovf1);
    logic [31:0] wraps;
    logic [31:0] span;
    while (n < CHANNELS) begin
      wraps = 0;
      span = 32'h10000 - shadow_count[n];
      if (ticks >= span) begin
        wraps = 1;
        ticks -= span;
        shadow_count[n] = shadow_reload[n];
        span = 32'h10000 - shadow_reload[n];
        if (ticks >= span) begin
          wraps += ticks / span;
          ticks = ticks % span;
        end
      end
      shadow_count[n] = 16'(shadow_count[n] + ticks);
      if (wraps == 0) return;
      if (shadow_irq[n]) irq[n] = 1'b1;
      if (n == 0) ovf0 += wraps;
      if (n == 1) ovf1 += wraps;
      n++;
      if (n >= CHANNELS || !shadow_cascade[n]) return;
      ticks = wraps;
    end
  endfunction

  function automatic ctu_pkg::out_item_t predict_timer_beat(ctu_pkg::in_item_t item);
    ctu_pkg::out_item_t res;
    logic [3:0] irq;
    logic [31:0] ovf0, ovf1, need, best;
    logic found, was_on;
    int avail, shift;
    irq = '0; ovf0 = 0; ovf1 = 0; best = 0; found = 1'b0;
    res = '0;
    case (item.opcode)
      ctu_pkg::OP_READ: begin
        case (item.register_offset)
          ctu_pkg::OFF_LOW:  res.read_data = shadow_count[item.channel][7:0];
          ctu_pkg::OFF_HIGH: res.read_data = shadow_count[item.channel][15:8];
          ctu_pkg::OFF_CTRL: res.read_data = {shadow_enable[item.channel],
                                              shadow_irq[item.channel], 3'b000,
                                              shadow_cascade[item.channel],
                                              shadow_prescale[item.channel]};
          default:  res.read_data = 8'h00;
        endcase
      end
      ctu_pkg::OP_WRITE: begin
        case (item.register_offset)
          ctu_pkg::OFF_LOW:  shadow_reload[item.channel][7:0] = item.write_data;
          ctu_pkg::OFF_HIGH: shadow_reload[item.channel][15:8] = item.write_data;
          ctu_pkg::OFF_CTRL: begin
            was_on = shadow_enable[item.channel];
            shadow_prescale[item.channel] = item.write_data[1:0];
            shadow_irq[item.channel] = item.write_data[CTRL_IRQ];
            shadow_enable[item.channel] = item.write_data[CTRL_ENABLE];
            if (item.channel != 0)
              shadow_cascade[item.channel] = item.write_data[CTRL_CASCADE];
            if (!was_on && shadow_enable[item.channel]) begin
              shadow_residue[item.channel] = -2;
              shadow_count[item.channel] = shadow_reload[item.channel];
            end
            refresh_chains();
          end
          default: ;
        endcase
      end
      ctu_pkg::OP_RUN: begin
        for (int n = 0; n < CHANNELS; n++) begin
          if (shadow_enable[n] && !shadow_cascade[n]) begin
            avail = shadow_residue[n] + int'(item.elapsed_cycles);
            if (avail < 0) begin
              shadow_residue[n] = avail;
            end else begin
              shift = shadow_prescale[n] == 0 ? 0 : 4 + 2 * shadow_prescale[n];
              add_ticks(n, 32'(avail) >> shift, irq, ovf0, ovf1);
              shadow_residue[n] = avail & ((1 << shift) - 1);
            end
          end
        end
      end
      default: ;
    endcase
    for (int n = 0; n < CHANNELS; n++) begin
      if ((shadow_irq[n] || shadow_feeds_irq[n]) && shadow_enable[n] && !shadow_cascade[n])
      begin
        shift = shadow_prescale[n] == 0 ? 0 : 4 + 2 * shadow_prescale[n];
        need = ((32'h10000 - shadow_count[n]) << shift) - 32'(shadow_residue[n]);
        if (!found || need < best) begin
          best = need;
          found = 1'b1;
        end
      end
    end
    res.irq_raised = irq;
    res.overflows_timer0 = ovf0[15:0];
    res.overflows_timer1 = ovf1[15:0];
    res.cycles_until_irq = best[26:0];
    res.irq_estimate_valid = found;
    return res;
  endfunction

  // Sends one beat, with a random gap ahead of it, and records its prediction
  // at the edge where it is accepted. Valid stays high into the next beat.
  task automatic send_timer_beat(logic [1:0] op, logic [1:0] ch, logic [1:0] off,
                                 logic [7:0] data, logic [15:0] cycles);
    ctu_pkg::in_item_t item;
    item = '{opcode: op, channel: ch, register_offset: off, write_data: data,
             elapsed_cycles: cycles};
    if (!quiet && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (!quiet && $urandom_range(99) < 26) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= item;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_timer_beat(item));
  endtask

  task automatic write_control(int ch, logic [1:0] ps, logic cas, logic irq, logic en);
    send_timer_beat(ctu_pkg::OP_WRITE, 2'(ch), ctu_pkg::OFF_CTRL,
                    {en, irq, 3'b000, cas, ps}, 16'd0);
  endtask

  task automatic write_reload(int ch, logic [15:0] value);
    send_timer_beat(ctu_pkg::OP_WRITE, 2'(ch), ctu_pkg::OFF_LOW, value[7:0], 16'd0);
    send_timer_beat(ctu_pkg::OP_WRITE, 2'(ch), ctu_pkg::OFF_HIGH, value[15:8], 16'd0);
  endtask

  task automatic read_all(int ch);
    for (int off = 0; off < 4; off++)
      send_timer_beat(ctu_pkg::OP_READ, 2'(ch), 2'(off), 8'hFF, 16'd0);
  endtask

  // Receiver side: random stalls, plus the long counted hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (stall_request > 0) begin
      out_ch.ready <= 1'b0;
      stall_request <= stall_request - 1;
    end else begin
      out_ch.ready <= quiet || ($urandom_range(99) >= 26);
    end
  end

  // Result checker: every accepted output beat is compared with the oldest prediction.
  always @(posedge clk) begin
    ctu_pkg::out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_ch.payload);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.payload.irq_raised != 0) irq_beats++;
        if (out_ch.payload.overflows_timer0 != 0) overflow_beats++;
        if (out_ch.payload.read_data != want.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                   out_ch.payload.read_data);
          error_count++;
        end
        if (out_ch.payload.irq_raised != want.irq_raised) begin
          $display("%0t: irq_raised expected %h actual %h", $time, want.irq_raised,
                   out_ch.payload.irq_raised);
          error_count++;
        end
        if (out_ch.payload.overflows_timer0 != want.overflows_timer0) begin
          $display("%0t: overflows_timer0 expected %0d actual %0d", $time,
                   want.overflows_timer0, out_ch.payload.overflows_timer0);
          error_count++;
        end
        if (out_ch.payload.overflows_timer1 != want.overflows_timer1) begin
          $display("%0t: overflows_timer1 expected %0d actual %0d", $time,
                   want.overflows_timer1, out_ch.payload.overflows_timer1);
          error_count++;
        end
        if (out_ch.payload.cycles_until_irq != want.cycles_until_irq) begin
          $display("%0t: cycles_until_irq expected %0d actual %0d", $time,
                   want.cycles_until_irq, out_ch.payload.cycles_until_irq);
          error_count++;
        end
        if (out_ch.payload.irq_estimate_valid != want.irq_estimate_valid) begin
          $display("%0t: irq_estimate_valid expected %b actual %b", $time,
                   want.irq_estimate_valid, out_ch.payload.irq_estimate_valid);
          error_count++;
        end
      end
    end
  end

  // Register access: reload bytes, control fields, unused offset and opcode.
  task automatic test_register_access();
    write_reload(0, 16'hFFFF);
    write_reload(3, 16'h0000);
    send_timer_beat(ctu_pkg::OP_WRITE, 2'd2, OFF_UNUSED, 8'hFF, 16'hFFFF);
    // Channel zero must keep its cascade bit clear.
    write_control(0, 2'd3, 1'b1, 1'b1, 1'b0);
    read_all(0);
    write_control(1, 2'd2, 1'b1, 1'b0, 1'b1);
    read_all(1);
    send_timer_beat(OP_NOP, 2'd3, 2'd3, 8'hFF, 16'hFFFF);
    write_control(1, 2'd0, 1'b0, 1'b0, 1'b0);
    write_control(0, 2'd0, 1'b0, 1'b0, 1'b0);
  endtask

  // Start delay: a short run leaves the residue negative and the count alone.
  task automatic test_start_delay();
    write_reload(0, 16'hFFF0);
    write_control(0, 2'd0, 1'b0, 1'b1, 1'b1);
    send_timer_beat(ctu_pkg::OP_RUN, 2'd0, 2'd0, 8'd0, 16'd0);
    send_timer_beat(ctu_pkg::OP_RUN, 2'd0, 2'd0, 8'd0, 16'd1);
    send_timer_beat(ctu_pkg::OP_RUN, 2'd0, 2'd0, 8'd0, 16'd1);
    read_all(0);
    // Many overflows in one run, counted by division.
    send_timer_beat(ctu_pkg::OP_RUN, 2'd0, 2'd0, 8'd0, 16'hFFFF);
  endtask

  // Cascade chain: timer 0 overflows ripple into 1..3; timers 1 and 3 have irq enabled.
  task automatic test_cascade_chain();
    write_control(0, 2'd0, 1'b0, 1'b0, 1'b0);
    write_reload(0, 16'hFF00);
    write_reload(1, 16'hFFFE);
    write_reload(2, 16'hFFFF);
    write_control(3, 2'd0, 1'b1, 1'b1, 1'b1);
    write_control(2, 2'd1, 1'b1, 1'b0, 1'b1);
    write_control(1, 2'd0, 1'b1, 1'b1, 1'b1);
    write_control(0, 2'd1, 1'b0, 1'b0, 1'b1);
    send_timer_beat(ctu_pkg::OP_RUN, 2'd0, 2'd0, 8'd0, 16'hFFFF);
    read_all(3);
  endtask

  // Backpressure: receiver holds off long while the sender keeps offering.
  task automatic test_output_stall();
    stall_request = 300;
    for (int i = 0; i < 12; i++)
      send_timer_beat(ctu_pkg::OP_RUN, 2'd0, 2'd0, 8'd0, 16'(i * 97));
  endtask

  // Mostly setup-then-run sequences with random content, plus raw noise.
  task automatic test_random_traffic(int beats);
    int sent;
    int ch;
    sent = 0;
    while (sent < beats) begin
      // A long stretch with no gaps on either side, in the middle of the run.
      quiet = (sent > beats / 3 && sent < beats / 2);
      case ($urandom_range(9))
        0, 1: begin
          ch = $urandom_range(3);
          write_reload(ch, $urandom_range(3) == 0 ? 16'(16'hFFFF - $urandom_range(40))
                                                  : 16'($urandom));
          sent += 2;
        end
        2, 3: begin
          send_timer_beat(ctu_pkg::OP_WRITE, 2'($urandom_range(3)), ctu_pkg::OFF_CTRL,
                          8'($urandom), 16'd0);
          sent++;
        end
        4, 5, 6: begin
          send_timer_beat(ctu_pkg::OP_RUN, 2'($urandom), 2'($urandom), 8'($urandom),
                          $urandom_range(1) ? 16'($urandom_range(4)) : 16'($urandom));
          sent++;
        end
        7, 8: begin
          send_timer_beat(ctu_pkg::OP_READ, 2'($urandom), 2'($urandom), 8'($urandom),
                          16'($urandom));
          sent++;
        end
        default: begin
          send_timer_beat(2'($urandom), 2'($urandom), 2'($urandom), 8'($urandom),
                          16'($urandom));
          sent++;
        end
      endcase
    end
    quiet = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    for (int n = 0; n < CHANNELS; n++) begin
      shadow_count[n] = '0; shadow_reload[n] = '0; shadow_residue[n] = 0;
      shadow_prescale[n] = '0; shadow_cascade[n] = 1'b0; shadow_irq[n] = 1'b0;
      shadow_enable[n] = 1'b0; shadow_feeds_irq[n] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_start_delay();
    test_cascade_chain();
    test_output_stall();
    test_random_traffic(545);
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("Covered register access, start delay, cascade ripple, output backpressure");
    $display("and random traffic: %0d results, %0d with irq, %0d with timer 0 overflow.",
             result_count, irq_beats, overflow_beats);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of about 600 beats.
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
